>>> sv/bda_pkg.sv
// Shared constants and types for the binary to decimal ASCII converter.
package bda_pkg;

    // Width of the integer that is converted; bits of tdata above it are ignored.
    localparam int VALUE_WIDTH = 64;
    // Width of the input tdata field.
    localparam int DATA_WIDTH  = 64;

    // Decimal digits needed for the largest unsigned value of VALUE_WIDTH bits.
    localparam int NUM_DIGITS  = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int BCD_WIDTH   = NUM_DIGITS * 4;

    // Step counter of the converter and digit counter of the emitter.
    localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH + 1);
    localparam int LEFT_WIDTH  = $clog2(NUM_DIGITS + 1);

    // Output character.
    localparam int CHAR_WIDTH  = 6;
    localparam int OUT_WIDTH   = 8;

    localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 6'd48;
    localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 6'd45;

    typedef logic [VALUE_WIDTH-1:0] t_value;
    typedef logic [BCD_WIDTH-1:0]   t_bcd;

endpackage

>>> sv/binary_to_decimal_ascii_core.sv
// Top level of the binary to decimal ASCII converter: sequencer and output stage.
// One input transfer carries an integer (tdata) and a signed flag (tuser); the block
// answers with its decimal text, one ASCII character per output transfer, most
// significant digit first, no leading zeros, '-' first for a negative signed value,
// tlast on the final digit. The input is taken only while the block is idle. The
// magnitude goes through a shift-add-3 converter, one bit per cycle; the digit register
// is then scanned one digit per cycle, skipping leading zeros and sending one
// character per cycle, as long as the output is not stalled.
module binary_to_decimal_ascii_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              s_axis_tvalid,
    output logic                              s_axis_tready,
    input  logic [bda_pkg::DATA_WIDTH-1:0]    s_axis_tdata,  // [63:0] value_bits
    input  logic                              s_axis_tuser,  // [0] signed_mode
    output logic                              m_axis_tvalid,
    input  logic                              m_axis_tready,
    output logic [bda_pkg::OUT_WIDTH-1:0]     m_axis_tdata,  // [5:0] text_char, [7:6] zero
    output logic                              m_axis_tlast   // last_char
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_MINUS,
        S_EMIT
    } t_state;

    t_state                                r_state, n_state;
    logic                                  r_neg, n_neg;
    bda_pkg::t_bcd                         r_digits, n_digits;
    logic [bda_pkg::LEFT_WIDTH-1:0]        r_left, n_left;
    logic                                  r_started, n_started;
    logic                                  r_m_valid, n_m_valid;
    logic [bda_pkg::CHAR_WIDTH-1:0]        r_m_char, n_m_char;
    logic                                  r_m_last, n_m_last;

    bda_pkg::t_value                       in_val;
    bda_pkg::t_value                       in_mag;
    logic                                  in_neg;
    logic                                  dab_start;
    bda_pkg::t_bcd                         dab_bcd;
    logic                                  dab_done;
    logic                                  out_free;
    logic [3:0]                            top_digit;

    assign in_val    = s_axis_tdata[bda_pkg::VALUE_WIDTH-1:0];
    assign in_neg    = s_axis_tuser & in_val[bda_pkg::VALUE_WIDTH-1];
    assign in_mag    = in_neg ? (bda_pkg::VALUE_WIDTH'(0) - in_val) : in_val;
    assign out_free  = !r_m_valid || m_axis_tready;
    assign top_digit = r_digits[bda_pkg::BCD_WIDTH-1 -: 4];

    bda_dabble u_dabble (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (dab_start),
        .i_bin   (in_mag),
        .o_bcd   (dab_bcd),
        .o_done  (dab_done)
    );

    always_comb begin
        n_state   = r_state;
        n_neg     = r_neg;
        n_digits  = r_digits;
        n_left    = r_left;
        n_started = r_started;
        n_m_valid = r_m_valid && !m_axis_tready;
        n_m_char  = r_m_char;
        n_m_last  = r_m_last;
        dab_start = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    n_neg     = in_neg;
                    dab_start = 1'b1;
                    n_state   = S_CONV;
                end
            end
            S_CONV: begin
                if (dab_done) begin
                    n_digits  = dab_bcd;
                    n_left    = bda_pkg::LEFT_WIDTH'(bda_pkg::NUM_DIGITS);
                    n_started = 1'b0;
                    n_state   = r_neg ? S_MINUS : S_EMIT;
                end
            end
            S_MINUS: begin
                if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_char  = bda_pkg::CHAR_MINUS;
                    n_m_last  = 1'b0;
                    n_state   = S_EMIT;
                end
            end
            S_EMIT: begin
                if (!r_started && top_digit == 4'd0 &&
                    r_left != bda_pkg::LEFT_WIDTH'(1)) begin
                    // drop a leading zero
                    n_digits = {r_digits[bda_pkg::BCD_WIDTH-5:0], 4'd0};
                    n_left   = r_left - 1'b1;
                end else if (out_free) begin
                    n_m_valid = 1'b1;
                    n_m_char  = bda_pkg::CHAR_ZERO | {2'b00, top_digit};
                    n_m_last  = (r_left == bda_pkg::LEFT_WIDTH'(1));
                    n_digits  = {r_digits[bda_pkg::BCD_WIDTH-5:0], 4'd0};
                    n_left    = r_left - 1'b1;
                    n_started = 1'b1;
                    if (r_left == bda_pkg::LEFT_WIDTH'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_m_valid <= n_m_valid;
        end
        r_neg     <= n_neg;
        r_digits  <= n_digits;
        r_left    <= n_left;
        r_started <= n_started;
        r_m_char  <= n_m_char;
        r_m_last  <= n_m_last;
    end

    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {2'b00, r_m_char};
    assign m_axis_tlast  = r_m_last;

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (r_state == S_CONV))
        else $error("accepted transfer did not start a conversion");

    a_done_in_conv: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dab_done |-> (r_state == S_CONV))
        else $error("converter finished outside the conversion state");

    a_emit_has_digits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EMIT) |-> (r_left != '0))
        else $error("emitting with no digits left");

    a_minus_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_m_valid && r_m_char == bda_pkg::CHAR_MINUS) |-> !r_m_last)
        else $error("minus sign marked as last character");
`endif

endmodule

>>> sv/bda_dabble.sv
// Bit-serial shift-add-3 binary to BCD converter, one input bit per cycle.
module bda_dabble (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  bda_pkg::t_value   i_bin,
    output bda_pkg::t_bcd     o_bcd,
    output logic              o_done
);

    bda_pkg::t_value                     r_bin;
    bda_pkg::t_bcd                       r_bcd;
    logic [bda_pkg::CNT_WIDTH-1:0]       r_cnt;
    logic                                r_busy;
    logic                                r_done;
    bda_pkg::t_bcd                       adj_bcd;

    // Add 3 to every digit of 5 or more before the shift doubles it.
    always_comb begin
        for (int i = 0; i < bda_pkg::NUM_DIGITS; i++) begin
            if (r_bcd[4*i +: 4] >= 4'd5) begin
                adj_bcd[4*i +: 4] = r_bcd[4*i +: 4] + 4'd3;
            end else begin
                adj_bcd[4*i +: 4] = r_bcd[4*i +: 4];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy &&
                         r_cnt == bda_pkg::CNT_WIDTH'(bda_pkg::VALUE_WIDTH - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end

        if (i_start) begin
            r_bin <= i_bin;
            r_bcd <= '0;
            r_cnt <= '0;
        end else if (r_busy) begin
            // shift the top binary bit into the BCD word
            r_bcd <= {adj_bcd[bda_pkg::BCD_WIDTH-2:0], r_bin[bda_pkg::VALUE_WIDTH-1]};
            r_bin <= {r_bin[bda_pkg::VALUE_WIDTH-2:0], 1'b0};
            r_cnt <= r_cnt + 1'b1;
        end
    end

    assign o_bcd  = r_bcd;
    assign o_done = r_done;

endmodule
